>>> src/sensor_minmax_calibrate_normalize_assert.svh
// Assertion macros for the checker module of the sensor min/max normalizer
`ifndef SENSOR_MINMAX_CALIBRATE_NORMALIZE_ASSERT_SVH
`define SENSOR_MINMAX_CALIBRATE_NORMALIZE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define SMCN_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SMCN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/smcn_pkg.sv
// Package: constants, codes and types of the sensor min/max normalizer
package smcn_pkg;

    localparam int SMCN_CHANNELS    = 5;
    localparam int SMCN_SAMPLE_BITS = 16;

    localparam int KIND_BITS      = 2;
    localparam int CHAN_BITS      = 3;
    localparam int SAMPLE_W       = 16;
    localparam int LEVEL_BITS     = 10;
    localparam int MIN_RESET      = 10000;
    localparam int MIN_RESET_BITS = 14;
    localparam int FULL_SCALE     = 1000;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_CAL   = 2'd0,
        KIND_NORM  = 2'd1,
        KIND_RESET = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

>>> src/smcn_if.sv
// Valid/ready channel interfaces for input items and result items
interface smcn_in_if import smcn_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [KIND_BITS-1:0] kind;
    logic [CHAN_BITS-1:0] channel;
    logic [SAMPLE_W-1:0]  sample;

    modport source (output valid, output kind, output channel, output sample, input ready);
    modport sink   (input valid, input kind, input channel, input sample, output ready);
endinterface

interface smcn_out_if import smcn_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CHAN_BITS-1:0]  out_channel;
    logic [LEVEL_BITS-1:0] level;

    modport source (output valid, output out_channel, output level, input ready);
    modport sink   (input valid, input out_channel, input level, output ready);
endinterface

>>> src/smcn_div.sv
// Iterative restoring divider: one quotient bit per cycle, quotient below 2**LEVEL_BITS
module smcn_div import smcn_pkg::*; #(
    parameter int NW = 26,
    parameter int DW = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [NW-1:0]         i_num,
    input  logic [DW-1:0]         i_den,
    output t_div_stat             o_stat,
    output logic [LEVEL_BITS-1:0] o_quot
);

    localparam int CNTW = $clog2(LEVEL_BITS);

    logic                  r_busy;
    logic                  r_done;
    logic [CNTW-1:0]       r_cnt;
    logic [NW-1:0]         r_rem;
    logic [NW-1:0]         r_dsh;
    logic [LEVEL_BITS-1:0] r_quot;
    logic                  w_ge;

    assign w_ge = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            // align the divisor with the top quotient bit
            r_dsh <= NW'(i_den) << (LEVEL_BITS - 1);
            r_cnt <= CNTW'(LEVEL_BITS - 1);
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_quot <= {r_quot[LEVEL_BITS-2:0], w_ge};
            r_dsh  <= r_dsh >> 1;
            r_cnt  <= r_cnt - CNTW'(1);
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

endmodule

>>> src/sensor_minmax_calibrate_normalize.sv
// Top level: per-channel min/max calibration and 0..1000 normalization of sensor counts
//
// Each channel keeps the smallest and largest sample seen since the last
// calibration reset (reset: minimum 10000, maximum 0). Calibrate and reset
// items are absorbed in the cycle they are accepted and give no result, so the
// input stays ready. A normalize item of a valid channel holds the input off
// while it compares against the stored range and forms (sample - min) * 1000,
// runs the restoring divider (one quotient bit per cycle), takes the quotient
// and loads the output register. Samples below the minimum give 0, above the
// maximum give 1000, and an empty range gives 0; these skip the divider. A
// stalled output register holds the next result back, and the input with it,
// until the waiting result is taken. Items with kind 3, and calibrate or
// normalize items with a channel beyond CHANNELS-1, are dropped.
module sensor_minmax_calibrate_normalize import smcn_pkg::*; #(
    parameter int CHANNELS    = SMCN_CHANNELS,
    parameter int SAMPLE_BITS = SMCN_SAMPLE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    smcn_in_if.sink     i_in,
    smcn_out_if.source  o_out
);

    localparam int VW = (SAMPLE_BITS > MIN_RESET_BITS) ? SAMPLE_BITS : MIN_RESET_BITS;
    localparam int NW = VW + LEVEL_BITS;
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int XW = SAMPLE_W + 32;

    t_state                r_state;
    t_state                n_state;
    logic [VW-1:0]         r_min [CHANNELS];
    logic [VW-1:0]         r_max [CHANNELS];
    logic [VW-1:0]         r_s;
    logic [CHAN_BITS-1:0]  r_ch;
    logic [CW-1:0]         r_idx;
    logic [LEVEL_BITS-1:0] r_level;
    logic                  r_out_valid;
    logic [LEVEL_BITS-1:0] r_out_level;
    logic [CHAN_BITS-1:0]  r_out_ch;

    logic                  w_acc;
    logic                  w_ch_ok;
    logic [CW+CHAN_BITS-1:0] w_chx;
    logic [CW-1:0]         w_idx;
    logic [XW-1:0]         w_sx;
    logic [VW-1:0]         w_s;
    logic [VW-1:0]         w_lo;
    logic [VW-1:0]         w_hi;
    logic [VW-1:0]         w_den;
    logic [NW-1:0]         w_num;
    logic                  w_below;
    logic                  w_above;
    logic                  w_short;
    logic                  w_start;
    logic                  w_load_out;
    t_div_stat             w_div_stat;
    logic [LEVEL_BITS-1:0] w_quot;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_ch_ok    = (int'(i_in.channel) < CHANNELS);
    assign w_chx      = (CW + CHAN_BITS)'(i_in.channel);
    assign w_idx      = w_chx[CW-1:0];
    assign w_sx       = XW'(i_in.sample);
    assign w_s        = VW'(w_sx & ((XW'(1) << SAMPLE_BITS) - XW'(1)));

    // range of the latched channel
    assign w_lo    = r_min[r_idx];
    assign w_hi    = r_max[r_idx];
    assign w_below = (r_s < w_lo);
    assign w_above = (r_s > w_hi);
    assign w_den   = w_hi - w_lo;
    assign w_short = w_below || w_above || (w_den == '0);
    assign w_num   = NW'(r_s - w_lo) * NW'(FULL_SCALE);
    assign w_start = (r_state == ST_CHECK) && !w_short;

    assign w_load_out = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);

    smcn_div #(
        .NW (NW),
        .DW (VW)
    ) u_smcn_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_stat  (w_div_stat),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_acc && (i_in.kind == KIND_NORM) && w_ch_ok) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = w_short ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
                if (w_div_stat.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // calibration ranges
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_min[i] <= VW'(MIN_RESET);
                r_max[i] <= '0;
            end
        end else if (w_acc) begin
            case (i_in.kind)
                KIND_RESET: begin
                    for (int i = 0; i < CHANNELS; i++) begin
                        r_min[i] <= VW'(MIN_RESET);
                        r_max[i] <= '0;
                    end
                end
                KIND_CAL: begin
                    if (w_ch_ok) begin
                        if (w_s < r_min[w_idx]) begin
                            r_min[w_idx] <= w_s;
                        end
                        if (w_s > r_max[w_idx]) begin
                            r_max[w_idx] <= w_s;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // latch the normalize item and collect its level
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s   <= w_s;
            r_ch  <= i_in.channel;
            r_idx <= w_idx;
        end
        if (r_state == ST_CHECK) begin
            // below the minimum wins over above the maximum on an inverted range
            r_level <= (w_above && !w_below) ? LEVEL_BITS'(FULL_SCALE) : '0;
        end else if ((r_state == ST_DIV) && w_div_stat.done) begin
            r_level <= w_quot;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_level <= r_level;
            r_out_ch    <= r_ch;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.level       = r_out_level;
    assign o_out.out_channel = r_out_ch;

endmodule

>>> src/smcn_chk.sv
// Port checker for the sensor min/max normalizer, bound to the top level
`include "sensor_minmax_calibrate_normalize_assert.svh"

module smcn_chk import smcn_pkg::*; #(
    parameter int CHANNELS = SMCN_CHANNELS
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic [KIND_BITS-1:0]  i_in_kind,
    input logic [CHAN_BITS-1:0]  i_in_channel,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [CHAN_BITS-1:0]  i_out_channel,
    input logic [LEVEL_BITS-1:0] i_out_level
);

    logic w_norm_acc;

    assign w_norm_acc = i_in_valid && i_in_ready && (i_in_kind == KIND_NORM)
                        && (int'(i_in_channel) < CHANNELS);

    `SMCN_ASSERT_SAME(a_level_range, i_clk, i_rst_n, i_out_valid,
        i_out_level <= LEVEL_BITS'(FULL_SCALE), "level above full scale")
    `SMCN_ASSERT_SAME(a_channel_range, i_clk, i_rst_n, i_out_valid,
        int'(i_out_channel) < CHANNELS, "result on a channel that does not exist")
    `SMCN_ASSERT_NEXT(a_busy_after_norm, i_clk, i_rst_n, w_norm_acc,
        !i_in_ready, "input ready while a normalize item is in work")
    `SMCN_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_level) && $stable(i_out_channel),
        "stalled result changed or dropped")

endmodule

bind sensor_minmax_calibrate_normalize smcn_chk #(
    .CHANNELS (CHANNELS)
) u_smcn_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_kind     (i_in.kind),
    .i_in_channel  (i_in.channel),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_channel (o_out.out_channel),
    .i_out_level   (o_out.level)
);
